// ===== sv/sccb_pkg.sv =====
`timescale 1ns / 1ps

package sccb_pkg;

	localparam int DATA_BITS_DEF = 8;
	localparam int OP_W = 3;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_IDLE  = 3'd0;
	localparam op_t OP_START = 3'd1;
	localparam op_t OP_STOP  = 3'd2;
	localparam op_t OP_WRITE = 3'd3;
	localparam op_t OP_READ  = 3'd4;
	localparam op_t OP_NACK  = 3'd5;

endpackage

// ===== sv/sccb_bit_master.sv =====
`timescale 1ns / 1ps

// Two-wire SCCB bit-level master. Each input item is one half-period tick that
// carries an operation code, the byte to send and the sampled data-line level;
// each accepted item yields exactly one result item with the clock and data
// line controls, busy/done, acknowledge status, the receive shift register
// and a rejection flag. An operation starts only while idle (start 3 ticks,
// stop 3, no-ack 4, write 2*DATA_BITS+3, read 2*DATA_BITS+1); one given while
// busy, or an undefined code, is ignored and flagged. One item is taken per
// clock as long as results are taken: the sequencer state and the result
// register update in the cycle the item is accepted, so its result is offered
// in the next cycle. A result held downstream stalls the input, and the next
// item enters in the same cycle that the held result leaves.
module sccb_bit_master
	import sccb_pkg::*;
#(
	parameter int DATA_BITS = DATA_BITS_DEF,
	localparam int IN_BITS  = OP_W + DATA_BITS + 1,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 7 + DATA_BITS,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// operation[2:0], tx_byte, sda_in, zero fill
	input  logic [IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// scl_level, sda_drive, sda_release, busy_res, done_res, ack_ok, rx_byte,
	// op_rejected, zero fill
	output logic [OUT_W-1:0] m_tdata
);

	localparam int PHASE_W  = $clog2(2 * DATA_BITS + 3);

	localparam logic [PHASE_W-1:0] PH_0   = PHASE_W'(0);
	localparam logic [PHASE_W-1:0] PH_1   = PHASE_W'(1);
	localparam logic [PHASE_W-1:0] PH_2   = PHASE_W'(2);
	localparam logic [PHASE_W-1:0] PH_3   = PHASE_W'(3);
	localparam logic [PHASE_W-1:0] PH_REL = PHASE_W'(2 * DATA_BITS);
	localparam logic [PHASE_W-1:0] PH_CLK = PHASE_W'(2 * DATA_BITS + 1);

	op_t                  in_op;
	logic [DATA_BITS-1:0] in_tx;
	logic                 in_sda;

	op_t                  op_q, op_n;
	logic [PHASE_W-1:0]   phase_q, phase_n;
	logic [DATA_BITS-1:0] tx_q, tx_n;
	logic [DATA_BITS-1:0] rx_q, rx_n;
	logic                 scl_q, scl_n;
	logic                 sda_q, sda_n;
	logic                 rel_q, rel_n;
	logic                 ack_q, ack_n;
	logic                 done_n, rej_n;

	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;
	logic                 accept;

	assign in_op  = s_tdata[OP_W-1:0];
	assign in_tx  = s_tdata[OP_W +: DATA_BITS];
	assign in_sda = s_tdata[OP_W+DATA_BITS];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		logic last;
		op_n    = op_q;
		phase_n = phase_q;
		tx_n    = tx_q;
		rx_n    = rx_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		rel_n   = rel_q;
		ack_n   = ack_q;
		rej_n   = 1'b0;
		done_n  = 1'b0;
		last    = 1'b0;

		if (op_q != OP_IDLE) begin
			rej_n = (in_op != OP_IDLE);
		end else if (in_op > OP_NACK) begin
			rej_n = 1'b1;
		end else if (in_op != OP_IDLE) begin
			op_n    = in_op;
			phase_n = PH_0;
			if (in_op == OP_WRITE) tx_n = in_tx;
			if (in_op == OP_READ) rx_n = '0;
		end

		if (op_n != OP_IDLE) begin
			unique case (op_n)
				OP_START: begin
					if (phase_n == PH_0) begin
						sda_n = 1'b1;
						scl_n = 1'b1;
					end else if (phase_n == PH_1) begin
						sda_n = 1'b0;
					end else begin
						scl_n = 1'b0;
						last  = 1'b1;
					end
				end
				OP_STOP: begin
					if (phase_n == PH_0) begin
						sda_n = 1'b0;
					end else if (phase_n == PH_1) begin
						scl_n = 1'b1;
					end else begin
						sda_n = 1'b1;
						last  = 1'b1;
					end
				end
				OP_NACK: begin
					if (phase_n == PH_1) begin
						sda_n = 1'b1;
						scl_n = 1'b1;
					end else if (phase_n == PH_2) begin
						scl_n = 1'b0;
					end else if (phase_n >= PH_3) begin
						sda_n = 1'b0;
						last  = 1'b1;
					end
				end
				OP_WRITE: begin
					if (phase_n < PH_REL) begin
						if (!phase_n[0]) begin
							if (phase_n != PH_0) scl_n = 1'b0;
							sda_n = tx_n[DATA_BITS-1];
							tx_n  = {tx_n[DATA_BITS-2:0], 1'b0};
						end else begin
							scl_n = 1'b1;
						end
					end else if (phase_n == PH_REL) begin
						scl_n = 1'b0;
						rel_n = 1'b1;
					end else if (phase_n == PH_CLK) begin
						scl_n = 1'b1;
					end else begin
						ack_n = !in_sda;
						scl_n = 1'b0;
						rel_n = 1'b0;
						last  = 1'b1;
					end
				end
				OP_READ: begin
					if (phase_n == PH_0) begin
						rel_n = 1'b1;
					end else if (phase_n[0]) begin
						scl_n = 1'b1;
						rx_n  = {rx_n[DATA_BITS-2:0], in_sda};
					end else begin
						scl_n = 1'b0;
						if (phase_n >= PH_REL) begin
							rel_n = 1'b0;
							last  = 1'b1;
						end
					end
				end
				default: last = 1'b1;
			endcase

			if (last) begin
				done_n  = 1'b1;
				op_n    = OP_IDLE;
				phase_n = PH_0;
			end else begin
				phase_n = phase_n + PH_1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= OP_IDLE;
			phase_q     <= '0;
			tx_q        <= '0;
			rx_q        <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			rel_q       <= 1'b0;
			ack_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				op_q        <= op_n;
				phase_q     <= phase_n;
				tx_q        <= tx_n;
				rx_q        <= rx_n;
				scl_q       <= scl_n;
				sda_q       <= sda_n;
				rel_q       <= rel_n;
				ack_q       <= ack_n;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= OUT_W'({rej_n, rx_n, ack_n, done_n, (op_n != OP_IDLE),
				rel_n, sda_n, scl_n});
		end
	end

endmodule

// ===== sim/sccb_bit_master_test.sv =====
`timescale 1ns / 1ps

module sccb_bit_master_test;
	import sccb_pkg::*;

	localparam int IN_W = 16;
	localparam int OUT_W = 16;
	localparam int NBITS = DATA_BITS_DEF;
	localparam int TICK_TARGET = 1650;
	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;

	// undefined operation codes
	localparam op_t OP_UNDEF6 = 3'd6;
	localparam op_t OP_UNDEF7 = 3'd7;

	typedef struct {
		logic       scl;
		logic       sda_drv;
		logic       rel;
		logic       busy;
		logic       done;
		logic       ack;
		logic [7:0] rx;
		logic       rej;
	} line_res_t;

	class sccb_line_model;
		op_t        cur_op;
		logic [4:0] step;
		logic [7:0] tx_sh;
		logic [7:0] rx_sh;
		logic       scl;
		logic       sda;
		logic       rel;
		logic       ack;
		line_res_t  pending[$];
		int         errors;
		int         checked;
		int         rejected;
		int         finished[8];

		function new();
			cur_op = OP_IDLE;
			step = '0;
			tx_sh = '0;
			rx_sh = '0;
			scl = 1'b1;
			sda = 1'b1;
			rel = 1'b0;
			ack = 1'b0;
			errors = 0;
			checked = 0;
			rejected = 0;
			foreach (finished[i]) finished[i] = 0;
		endfunction

		// one phase of the running sequence; 1 on its last phase
		function bit advance(logic sda_bit);
			case (cur_op)
			OP_START: begin
				if (step == 0) begin
					sda = 1'b1;
					scl = 1'b1;
				end else if (step == 1) begin
					sda = 1'b0;
				end else begin
					scl = 1'b0;
					return 1'b1;
				end
			end
			OP_STOP: begin
				if (step == 0) begin
					sda = 1'b0;
				end else if (step == 1) begin
					scl = 1'b1;
				end else begin
					sda = 1'b1;
					return 1'b1;
				end
			end
			OP_NACK: begin
				if (step == 1) begin
					sda = 1'b1;
					scl = 1'b1;
				end else if (step == 2) begin
					scl = 1'b0;
				end else if (step >= 3) begin
					sda = 1'b0;
					return 1'b1;
				end
			end
			OP_WRITE: begin
				if (step < 2 * NBITS) begin
					if (!step[0]) begin
						if (step != 0) scl = 1'b0;
						sda = tx_sh[7];
						tx_sh = {tx_sh[6:0], 1'b0};
					end else begin
						scl = 1'b1;
					end
				end else if (step == 2 * NBITS) begin
					scl = 1'b0;
					rel = 1'b1;
				end else if (step == 2 * NBITS + 1) begin
					scl = 1'b1;
				end else begin
					ack = (sda_bit == 1'b0);
					scl = 1'b0;
					rel = 1'b0;
					return 1'b1;
				end
			end
			OP_READ: begin
				if (step == 0) begin
					rel = 1'b1;
				end else if (step[0]) begin
					scl = 1'b1;
					rx_sh = {rx_sh[6:0], sda_bit};
				end else begin
					scl = 1'b0;
					if (step >= 2 * NBITS) begin
						rel = 1'b0;
						return 1'b1;
					end
				end
			end
			default: return 1'b1;
			endcase
			return 1'b0;
		endfunction

		function void take_tick(logic [IN_W-1:0] d);
			op_t       op;
			logic [7:0] txb;
			logic      sda_bit;
			line_res_t r;
			op = d[2:0];
			txb = d[10:3];
			sda_bit = d[11];
			r.rej = 1'b0;
			r.done = 1'b0;
			if (cur_op != OP_IDLE) begin
				if (op != OP_IDLE) r.rej = 1'b1;
			end else if (op > OP_NACK) begin
				r.rej = 1'b1;
			end else if (op != OP_IDLE) begin
				cur_op = op;
				step = '0;
				if (op == OP_WRITE) tx_sh = txb;
				if (op == OP_READ) rx_sh = '0;
			end
			if (cur_op != OP_IDLE) begin
				if (advance(sda_bit)) begin
					r.done = 1'b1;
					finished[cur_op]++;
					cur_op = OP_IDLE;
					step = '0;
				end else begin
					step = step + 5'd1;
				end
			end
			if (r.rej) rejected++;
			r.scl = scl;
			r.sda_drv = sda;
			r.rel = rel;
			r.busy = (cur_op != OP_IDLE);
			r.ack = ack;
			r.rx = rx_sh;
			pending.push_back(r);
		endfunction

		function void cmp(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_lines(logic [OUT_W-1:0] d);
			line_res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected item, expected none actual %h", $time, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			cmp("scl_level", e.scl, d[0]);
			cmp("sda_drive", e.sda_drv, d[1]);
			cmp("sda_release", e.rel, d[2]);
			cmp("busy_res", e.busy, d[3]);
			cmp("done_res", e.done, d[4]);
			cmp("ack_ok", e.ack, d[5]);
			cmp("rx_byte", e.rx, d[13:6]);
			cmp("op_rejected", e.rej, d[14]);
		endfunction
	endclass

	logic            clk;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	sccb_line_model lines = new();
	int  cycles = 0;
	int  ticks_sent = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	bit  calm = 1'b0;
	bit  hold_done = 1'b0;
	bit  paused = 1'b0;

	sccb_bit_master u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (s_tvalid && s_tready) lines.take_tick(s_tdata);
		if (m_tvalid && m_tready) lines.check_lines(m_tdata);
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 9);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout", $time);
		$display("sccb_bit_master_test failed");
		$finish;
	end

	task send_tick(op_t op, logic [7:0] txb, logic sda_bit);
		int gap;
		if (!calm && $urandom_range(99) < 9) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, sda_bit, txb, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ticks_sent++;
	endtask

	task drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (lines.pending.size() != 0) @(posedge clk);
	endtask

	task run_sequence();
		int         len;
		op_t        op;
		logic [7:0] txb;
		if ($urandom_range(99) < 8) begin
			send_tick(op_t'($urandom_range(7)), 8'($urandom), 1'($urandom));
			return;
		end
		op = op_t'($urandom_range(1, 5));
		if ($urandom_range(9) == 0)
			txb = $urandom_range(1) ? 8'hFF : 8'h00;
		else
			txb = 8'($urandom);
		case (op)
		OP_START, OP_STOP: len = 3;
		OP_NACK: len = 4;
		OP_WRITE: len = 2 * NBITS + 3;
		default: len = 2 * NBITS + 1;
		endcase
		send_tick(op, txb, 1'($urandom));
		for (int i = 1; i < len; i++) begin
			if ($urandom_range(99) < 6)
				send_tick(op_t'($urandom_range(1, 7)), 8'($urandom), 1'($urandom));
			else
				send_tick(OP_IDLE, 8'($urandom), 1'($urandom));
		end
		if ($urandom_range(3) == 0) send_tick(OP_IDLE, 8'($urandom), 1'($urandom));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle tick, undefined codes, start with a write refused mid-way
		send_tick(OP_IDLE, 8'h00, 1'b0);
		send_tick(OP_UNDEF6, 8'hFF, 1'b1);
		send_tick(OP_UNDEF7, 8'h00, 1'b0);
		send_tick(OP_START, 8'h00, 1'b1);
		send_tick(OP_WRITE, 8'hFF, 1'b0);
		send_tick(OP_IDLE, 8'h00, 1'b1);
		send_tick(OP_NACK, 8'hFF, 1'b0);
		repeat (3) send_tick(OP_IDLE, 8'h00, 1'b1);
		send_tick(OP_STOP, 8'h00, 1'b0);
		send_tick(OP_READ, 8'hFF, 1'b1);
		send_tick(OP_IDLE, 8'h00, 1'b0);
		drain();

		while (ticks_sent < TICK_TARGET) begin
			if (!hold_done && ticks_sent > 400) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!paused && ticks_sent > 900) begin
				drain();
				paused = 1'b1;
			end
			calm = (ticks_sent > 1100 && ticks_sent < 1350);
			run_sequence();
		end
		calm = 1'b0;
		drain();
		repeat (8) @(posedge clk);

		$display("%0d ticks checked; sequences done: start %0d, stop %0d, no-ack %0d,",
			lines.checked, lines.finished[OP_START], lines.finished[OP_STOP],
			lines.finished[OP_NACK]);
		$display("write %0d, read %0d; %0d operations refused", lines.finished[OP_WRITE],
			lines.finished[OP_READ], lines.rejected);
		if (lines.errors == 0 && lines.pending.size() == 0) begin
			$display("sccb_bit_master_test passed");
		end else begin
			$display("sccb_bit_master_test failed");
		end
		$finish;
	end

endmodule
